/* src/paged_bump_allocator_unit_assert.svh */
// Assertion macros for the paged bump allocator unit.
// Each expects clk and arst_n in scope.
`ifndef PAGED_BUMP_ALLOCATOR_UNIT_ASSERT_SVH
`define PAGED_BUMP_ALLOCATOR_UNIT_ASSERT_SVH

// Same-cycle implication.
`define PBA_ASSERT_IMP(lbl, pre, post) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) \
		else $error("assertion failed");

// Next-cycle implication.
`define PBA_ASSERT_NXT(lbl, pre, post) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error("assertion failed");

`endif

/* src/pba_pkg.sv */
`timescale 1ns / 1ps

package pba_pkg;

	localparam int MAX_PAGES      = 16;
	localparam int PAGE_W         = $clog2(MAX_PAGES);
	localparam int OFF_W          = 13;
	localparam int HDR_W          = 7;
	localparam int CFG_IDX_W      = 2;

	localparam logic [OFF_W-1:0] PAGE_BYTES_MAX   = 13'd4096;
	localparam logic [OFF_W-1:0] PAGE_BYTES_RESET = 13'd4096;
	localparam logic [HDR_W-1:0] HEADER_RESET     = 7'd24;

	typedef enum logic [1:0] {
		ST_DONE      = 2'd0,
		ST_OVERSIZE  = 2'd1,
		ST_EXHAUSTED = 2'd2
	} status_t;

	typedef enum logic {
		MODE_ALLOC   = 1'b0,
		MODE_RELEASE = 1'b1
	} mode_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_PAGE_BYTES   = 2'd0,
		CFG_HEADER_BYTES = 2'd1
	} cfg_idx_t;

	// request seen by every cell during the search cycle
	typedef struct packed {
		logic [OFF_W-1:0] size;
		logic [OFF_W-1:0] page_end;
		logic [HDR_W-1:0] hdr;
	} req_t;

	// commit strobes, decided from the chain result
	typedef struct packed {
		logic release_all;
		logic take;
		logic open_new;
	} upd_t;

	// travels from the newest page down to page 0
	typedef struct packed {
		logic              hit;
		logic [PAGE_W-1:0] hit_idx;
		logic [OFF_W-1:0]  hit_off;
		logic              new_hit;
		logic [PAGE_W-1:0] new_idx;
	} chain_t;

endpackage

/* src/pba_cell.sv */
`timescale 1ns / 1ps

// One page: open flag and free offset.
module pba_cell (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic [pba_pkg::PAGE_W-1:0] cell_idx,
	input  pba_pkg::req_t              req,
	input  pba_pkg::upd_t              upd,
	input  logic                       open_below,
	output logic                       open,
	input  pba_pkg::chain_t            dn_in,
	output pba_pkg::chain_t            dn_out
);

	logic                      open_q;
	logic [pba_pkg::OFF_W-1:0] off_q;
	logic [pba_pkg::OFF_W-1:0] room;
	logic [pba_pkg::OFF_W-1:0] hdr_ext;
	logic                      is_base;
	logic                      fit;
	logic                      take;
	logic                      opener;

	assign is_base = (cell_idx == '0);
	assign hdr_ext = pba_pkg::OFF_W'(req.hdr);
	assign room    = (off_q < req.page_end) ? (req.page_end - off_q) : '0;
	assign fit     = open_q && (req.size <= room);
	assign take    = fit && !dn_in.hit;
	// first closed page above the open run
	assign opener  = !open_q && open_below;
	assign open    = open_q;

	always_comb begin
		dn_out = dn_in;
		if (take) begin
			dn_out.hit     = 1'b1;
			dn_out.hit_idx = cell_idx;
			dn_out.hit_off = off_q;
		end
		if (opener) begin
			dn_out.new_hit = 1'b1;
			dn_out.new_idx = cell_idx;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			open_q <= is_base;
			off_q  <= pba_pkg::OFF_W'(pba_pkg::HEADER_RESET);
		end else if (upd.release_all) begin
			open_q <= is_base;
			if (is_base) begin
				off_q <= hdr_ext;
			end
		end else if (upd.take && take) begin
			off_q <= off_q + req.size;
		end else if (upd.open_new && opener) begin
			open_q <= 1'b1;
			off_q  <= hdr_ext + req.size;
		end
	end

endmodule

/* src/paged_bump_allocator_unit.sv */
`timescale 1ns / 1ps
// A result item is registered when the page cells search and commit, in the
// cycle after acceptance; a new input item is not taken while one is held, and
// the next item is taken once the result is posted.
// A result that is not taken holds the search cycle until the output frees.
// Reset (arst_n low, async): page_bytes 4096, header_bytes 24, page 0 open at 24.

module paged_bump_allocator_unit (
	input  logic                          clk,
	input  logic                          arst_n,
	// input items
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [15:0]                   s_tdata,   // [12:0] request_size, rest zero
	input  logic [0:0]                    s_tuser,   // [0] mode
	// result items
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [23:0]                   m_tdata,   // [3:0] page_index, [16:4] byte_offset
	output logic [1:0]                    m_tuser,   // [1:0] status
	// configuration writes
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [pba_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [15:0]                   cfg_data
);

	localparam int NP = pba_pkg::MAX_PAGES;

	// configuration
	logic [pba_pkg::OFF_W-1:0] page_bytes_q;
	logic [pba_pkg::HDR_W-1:0] header_bytes_q;

	// held request
	logic                      busy_q;
	logic                      mode_q;
	logic [pba_pkg::OFF_W-1:0] size_q;

	// result register
	logic                       out_valid_q;
	pba_pkg::status_t           status_q;
	logic [pba_pkg::PAGE_W-1:0] page_q;
	logic [pba_pkg::OFF_W-1:0]  offset_q;

	logic                      in_acc;
	logic                      out_free;
	logic                      commit;
	logic [pba_pkg::OFF_W-1:0] page_end;
	logic [pba_pkg::OFF_W-1:0] hdr_ext;
	logic [pba_pkg::OFF_W-1:0] fresh_room;
	logic                      oversize;
	logic                      is_release;

	pba_pkg::req_t   req;
	pba_pkg::upd_t   upd;
	pba_pkg::chain_t dn [0:NP];
	logic [NP-1:0]   open_vec;

	assign cfg_ready = 1'b1;
	assign s_tready  = !busy_q;
	assign in_acc    = s_tvalid && s_tready;
	assign out_free  = !out_valid_q || m_tready;
	assign commit    = busy_q && out_free;

	assign m_tvalid = out_valid_q;
	assign m_tuser  = status_q;
	assign m_tdata  = {7'd0, offset_q, page_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			page_bytes_q   <= pba_pkg::PAGE_BYTES_RESET;
			header_bytes_q <= pba_pkg::HEADER_RESET;
		end else if (cfg_valid) begin
			case (cfg_index)
				pba_pkg::CFG_PAGE_BYTES:   page_bytes_q   <= cfg_data[pba_pkg::OFF_W-1:0];
				pba_pkg::CFG_HEADER_BYTES: header_bytes_q <= cfg_data[pba_pkg::HDR_W-1:0];
				default: ;
			endcase
		end
	end

	// page end clamps to the largest page; fresh-page room checks oversize
	assign page_end   = (page_bytes_q > pba_pkg::PAGE_BYTES_MAX) ?
	                    pba_pkg::PAGE_BYTES_MAX : page_bytes_q;
	assign hdr_ext    = pba_pkg::OFF_W'(header_bytes_q);
	assign fresh_room = (hdr_ext < page_end) ? (page_end - hdr_ext) : '0;
	assign oversize   = (size_q > fresh_room);
	assign is_release = (mode_q == pba_pkg::MODE_RELEASE);

	assign req.size     = size_q;
	assign req.page_end = page_end;
	assign req.hdr      = header_bytes_q;

	// newest page is searched first: the chain runs from the top cell down
	assign dn[NP] = '0;

	genvar g;
	generate
		for (g = 0; g < NP; g++) begin : g_cell
			logic below;
			if (g == 0) begin : g_base
				assign below = 1'b1;
			end else begin : g_upper
				assign below = open_vec[g-1];
			end
			pba_cell u_cell (
				.clk        (clk),
				.arst_n     (arst_n),
				.cell_idx   (pba_pkg::PAGE_W'(g)),
				.req        (req),
				.upd        (upd),
				.open_below (below),
				.open       (open_vec[g]),
				.dn_in      (dn[g+1]),
				.dn_out     (dn[g])
			);
		end
	endgenerate

	// commit strobes from the chain result at page 0
	always_comb begin
		upd.release_all = commit && is_release;
		upd.take        = commit && !is_release && !oversize && dn[0].hit;
		upd.open_new    = commit && !is_release && !oversize && !dn[0].hit && dn[0].new_hit;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (in_acc) begin
				busy_q <= 1'b1;
			end else if (commit) begin
				busy_q <= 1'b0;
			end
			if (commit) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			mode_q <= s_tuser[0];
			size_q <= s_tdata[pba_pkg::OFF_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (commit) begin
			if (is_release) begin
				status_q <= pba_pkg::ST_DONE;
				page_q   <= '0;
				offset_q <= '0;
			end else if (oversize) begin
				status_q <= pba_pkg::ST_OVERSIZE;
				page_q   <= '0;
				offset_q <= '0;
			end else if (dn[0].hit) begin
				status_q <= pba_pkg::ST_DONE;
				page_q   <= dn[0].hit_idx;
				offset_q <= dn[0].hit_off;
			end else if (dn[0].new_hit) begin
				status_q <= pba_pkg::ST_DONE;
				page_q   <= dn[0].new_idx;
				offset_q <= hdr_ext;
			end else begin
				status_q <= pba_pkg::ST_EXHAUSTED;
				page_q   <= '0;
				offset_q <= '0;
			end
		end
	end

	`include "paged_bump_allocator_unit_assert.svh"

	// page 0 never closes
	`PBA_ASSERT_IMP(a_base_open, 1'b1, open_vec[0])
	// open pages form one run from page 0 up
	`PBA_ASSERT_IMP(a_open_run, 1'b1, (open_vec & (open_vec + NP'(1))) == '0)
	// a fresh result only ever follows a held request
	`PBA_ASSERT_IMP(a_result_source, $rose(out_valid_q), $past(busy_q))
	// an accepted item is held for the search cycle
	`PBA_ASSERT_NXT(a_accept_busy, in_acc, busy_q && !s_tready)
	// no page left to open only when every page is already open
	`PBA_ASSERT_IMP(a_exhaust_full, busy_q && !dn[0].new_hit, open_vec[NP-1])

endmodule

/* bench/testbench.sv */
`timescale 1ns / 1ps

module testbench;
	import pba_pkg::*;

	// Register index with no register behind it; a write there must change nothing.
	localparam logic [CFG_IDX_W-1:0] CFG_IDX_UNUSED = 2'd3;
	localparam int CYCLE_LIMIT = 400000;
	localparam int RANDOM_PHASES = 8;
	localparam int ITEMS_PER_PHASE = 56;

	// One request item as the sender sees it.
	typedef struct {
		mode_t            mode;
		logic [OFF_W-1:0] size;
	} alloc_req_t;

	// One expected result item.
	typedef struct {
		status_t           st;
		logic [PAGE_W-1:0] page;
		logic [OFF_W-1:0]  off;
	} grant_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic                 s_tvalid = 1'b0;
	logic                 s_tready;
	logic [15:0]          s_tdata = '0;   // [12:0] request_size
	logic [0:0]           s_tuser = '0;   // [0] mode
	logic                 m_tvalid;
	logic                 m_tready = 1'b0;
	logic [23:0]          m_tdata;        // [3:0] page_index, [16:4] byte_offset
	logic [1:0]           m_tuser;        // [1:0] status
	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [15:0]          cfg_data = '0;

	paged_bump_allocator_unit dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	// Pending requests, and the grants the pool model says must come back, oldest first.
	alloc_req_t pending_reqs[$];
	grant_t     expected_grants[$];
	alloc_req_t req_on_bus;
	grant_t     oldest_grant;

	// Shadow of the pool: configuration and per-page free offsets.
	logic [OFF_W-1:0] shadow_page_bytes = PAGE_BYTES_RESET;
	logic [HDR_W-1:0] shadow_header = HEADER_RESET;
	logic [OFF_W-1:0] shadow_free_off [MAX_PAGES];
	int               shadow_pages_open;

	int sender_idle_pct = 0;
	int recv_stall_pct = 0;
	int fail_count = 0;
	int cycle_count = 0;
	int results_checked = 0;
	int settings_used = 1;
	int n_grants = 0, n_oversize = 0, n_exhausted = 0, n_release = 0;

	// Settings for the random phases; the last one is drawn at run time.
	int phase_pb  [RANDOM_PHASES] = '{4096, 32, 64, 48, 4096, 256, 33, 0};
	int phase_hb  [RANDOM_PHASES] = '{24, 0, 16, 47, 0, 64, 32, 0};
	int phase_rel [RANDOM_PHASES] = '{6, 1, 2, 1, 4, 2, 1, 3};

	initial begin
		forever #4 clk = ~clk;
	end

	// Hard stop in case the block hangs on a handshake.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles, %0d results outstanding",
				cycle_count, expected_grants.size());
			$display("Some tests failed");
			$finish;
		end
	end

	task automatic report_mismatch(input string what, input int got, input int want);
		$display("MISMATCH result %0d: %s got %0d expected %0d",
			results_checked, what, got, want);
		fail_count++;
	endtask

	function automatic logic [OFF_W-1:0] room_left(input logic [OFF_W-1:0] lim,
			input logic [OFF_W-1:0] off);
		return (off < lim) ? lim - off : '0;
	endfunction

	// Pool model: works out the grant for one accepted request and updates the shadow.
	function automatic void predict_grant(input alloc_req_t rq);
		logic [OFF_W-1:0] lim;
		logic [OFF_W-1:0] hdr;
		grant_t           g;
		bit               served;
		int               p;
		lim = (shadow_page_bytes > PAGE_BYTES_MAX) ? PAGE_BYTES_MAX : shadow_page_bytes;
		hdr = {{(OFF_W-HDR_W){1'b0}}, shadow_header};
		g = '{ST_DONE, '0, '0};
		served = 1'b0;
		if (rq.mode == MODE_RELEASE) begin
			shadow_pages_open = 1;
			shadow_free_off[0] = hdr;
			n_release++;
		end else if (rq.size > room_left(lim, hdr)) begin
			// larger than even a fresh page can hold
			g.st = ST_OVERSIZE;
			n_oversize++;
		end else begin
			// newest page first, then the older ones
			for (p = shadow_pages_open - 1; p >= 0 && !served; p--) begin
				if (rq.size <= room_left(lim, shadow_free_off[p])) begin
					g.page = p[PAGE_W-1:0];
					g.off = shadow_free_off[p];
					shadow_free_off[p] = shadow_free_off[p] + rq.size;
					served = 1'b1;
				end
			end
			if (!served) begin
				if (shadow_pages_open >= MAX_PAGES) begin
					g.st = ST_EXHAUSTED;
					n_exhausted++;
				end else begin
					g.page = shadow_pages_open[PAGE_W-1:0];
					g.off = hdr;
					shadow_free_off[shadow_pages_open] = hdr + rq.size;
					shadow_pages_open++;
					served = 1'b1;
				end
			end
			if (served)
				n_grants++;
		end
		expected_grants.push_back(g);
	endfunction

	// Random request shaped around the room of a fresh page under the given setting.
	function automatic alloc_req_t random_req(input int pb, input int hb, input int release_pct);
		alloc_req_t rq;
		int         lim, fresh, roll, sz;
		lim = (pb > 4096) ? 4096 : pb;
		fresh = (lim > hb) ? lim - hb : 0;
		roll = $urandom_range(0, 99);
		rq.mode = MODE_ALLOC;
		if (roll < release_pct) begin
			rq.mode = MODE_RELEASE;
			sz = $urandom_range(0, 4096);   // size is don't-care on release
		end else if (roll < release_pct + 6)
			sz = 0;
		else if (roll < release_pct + 16)
			sz = (fresh < 4096) ? $urandom_range(fresh + 1, 4096) : 4096;
		else if (roll < release_pct + 30)
			sz = fresh - $urandom_range(0, (fresh < 3) ? fresh : 3);
		else if (roll < release_pct + 55)
			sz = $urandom_range(fresh / 2, fresh);
		else
			sz = $urandom_range(1, fresh / 4 + 1);
		rq.size = sz[OFF_W-1:0];
		return rq;
	endfunction

	function automatic alloc_req_t mk_req(input mode_t m, input int sz);
		alloc_req_t rq;
		rq.mode = m;
		rq.size = sz[OFF_W-1:0];
		return rq;
	endfunction

	// Request driver: predicts at acceptance, then presents the next pending item
	// unless this cycle is drawn as an idle one.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata <= '0;
			s_tuser <= '0;
		end else begin
			if (s_tvalid && s_tready)
				predict_grant(req_on_bus);
			if (!s_tvalid || s_tready) begin
				if (pending_reqs.size() != 0 && $urandom_range(0, 99) >= sender_idle_pct) begin
					req_on_bus = pending_reqs.pop_front();
					s_tvalid <= 1'b1;
					s_tdata <= {{(16-OFF_W){1'b0}}, req_on_bus.size};
					s_tuser <= req_on_bus.mode;
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// Result monitor: every accepted result is matched against the oldest grant.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if (m_tvalid && m_tready) begin
				if (expected_grants.size() == 0) begin
					report_mismatch("unexpected result, status", m_tuser, 0);
				end else begin
					oldest_grant = expected_grants.pop_front();
					if (m_tuser !== oldest_grant.st)
						report_mismatch("status", m_tuser, oldest_grant.st);
					if (m_tdata[3:0] !== oldest_grant.page)
						report_mismatch("page_index", m_tdata[3:0], oldest_grant.page);
					if (m_tdata[16:4] !== oldest_grant.off)
						report_mismatch("byte_offset", m_tdata[16:4], oldest_grant.off);
				end
				results_checked++;
			end
			m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
		end
	end

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] val);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_valid <= 1'b0;
		// shadow follows the write; unused indexes are no-ops
		if (idx == CFG_PAGE_BYTES)
			shadow_page_bytes = val[OFF_W-1:0];
		else if (idx == CFG_HEADER_BYTES)
			shadow_header = val[HDR_W-1:0];
	endtask

	// Hold until every request went out and every grant came back, then let the
	// pipeline settle.
	task automatic wait_idle();
		while (pending_reqs.size() != 0 || s_tvalid || expected_grants.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic set_idling(input int mode_sel);
		@(negedge clk);
		case (mode_sel)
			0: begin
				sender_idle_pct = 0;
				recv_stall_pct = 0;
			end
			1: begin
				sender_idle_pct = 79;
				recv_stall_pct = 0;
			end
			2: begin
				sender_idle_pct = 0;
				recv_stall_pct = 79;
			end
			default: begin
				sender_idle_pct = 16;
				recv_stall_pct = 16;
			end
		endcase
	endtask

	initial begin
		int ph, k, pb, hb;
		for (k = 0; k < MAX_PAGES; k++)
			shadow_free_off[k] = '0;
		shadow_free_off[0] = {{(OFF_W-HDR_W){1'b0}}, HEADER_RESET};
		shadow_pages_open = 1;

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// Directed, reset setting: zero size, exact fit, oversize, full page,
		// opening pages and falling back to an older page.
		set_idling(0);
		pending_reqs.push_back(mk_req(MODE_ALLOC, 0));
		pending_reqs.push_back(mk_req(MODE_ALLOC, 4072));
		pending_reqs.push_back(mk_req(MODE_ALLOC, 4073));
		pending_reqs.push_back(mk_req(MODE_ALLOC, 4096));
		pending_reqs.push_back(mk_req(MODE_ALLOC, 0));
		pending_reqs.push_back(mk_req(MODE_ALLOC, 1));
		pending_reqs.push_back(mk_req(MODE_ALLOC, 4072));
		pending_reqs.push_back(mk_req(MODE_ALLOC, 5));
		pending_reqs.push_back(mk_req(MODE_RELEASE, 8191));
		wait_idle();

		// Page size above the maximum is clamped; no header so a whole page fits.
		write_reg(CFG_PAGE_BYTES, 16'd5000);
		write_reg(CFG_HEADER_BYTES, 16'd0);
		settings_used++;
		@(negedge clk);
		pending_reqs.push_back(mk_req(MODE_ALLOC, 4096));
		pending_reqs.push_back(mk_req(MODE_ALLOC, 4096));
		pending_reqs.push_back(mk_req(MODE_ALLOC, 0));
		pending_reqs.push_back(mk_req(MODE_RELEASE, 0));
		wait_idle();

		// Header larger than the page: no room in a fresh page, stored offsets kept.
		write_reg(CFG_PAGE_BYTES, 16'd32);
		write_reg(CFG_HEADER_BYTES, 16'd64);
		write_reg(CFG_IDX_UNUSED, 16'hFFFF);
		settings_used++;
		@(negedge clk);
		pending_reqs.push_back(mk_req(MODE_ALLOC, 0));
		pending_reqs.push_back(mk_req(MODE_ALLOC, 1));
		pending_reqs.push_back(mk_req(MODE_RELEASE, 4096));
		pending_reqs.push_back(mk_req(MODE_ALLOC, 0));
		wait_idle();

		// Random phases; the drain between phases is also the sender's long pause.
		for (ph = 0; ph < RANDOM_PHASES; ph++) begin
			if (ph == RANDOM_PHASES - 1) begin
				pb = $urandom_range(32, 4096);
				hb = $urandom_range(0, 64);
			end else begin
				pb = phase_pb[ph];
				hb = phase_hb[ph];
			end
			write_reg(CFG_PAGE_BYTES, pb[15:0]);
			write_reg(CFG_HEADER_BYTES, hb[15:0]);
			settings_used++;
			set_idling(ph % 4);
			for (k = 0; k < ITEMS_PER_PHASE; k++)
				pending_reqs.push_back(random_req(pb, hb, phase_rel[ph]));
			wait_idle();
		end

		repeat (8) @(posedge clk);
		$display("Checked %0d results over %0d register settings and four idling patterns",
			results_checked, settings_used);
		$display("grants %0d, oversized %0d, pool full %0d, releases %0d",
			n_grants, n_oversize, n_exhausted, n_release);
		if (fail_count == 0 && expected_grants.size() == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

endmodule

/* sim.f */
+incdir+src
src/pba_pkg.sv
src/pba_cell.sv
src/paged_bump_allocator_unit.sv
bench/testbench.sv
